/* src/fgs_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// fgs_pkg - shared types and constants of the fuzzy gain scheduler
// Rule tables, level register defaults, register indexes and the word
// types that travel between the front end, the queue and the back end.
// ============================================================================
package fgs_pkg;

  localparam int LEVEL_W    = 10;
  localparam int NUM_LEVELS = 4;
  localparam int CORNERS    = 4;
  localparam int OUT_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int GRID_N     = 7;

  localparam logic [OUT_W-1:0] OUT_MAX  = 18'h3FFFF;
  localparam logic [2:0]       CELL_MAX = 3'd5;

  // Queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KP_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KD_ZERO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_ONE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KD_TWO   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KD_THREE = 3'd7;

  typedef logic [LEVEL_W-1:0]                  fgs_level_t;
  typedef logic [NUM_LEVELS-1:0][LEVEL_W-1:0]  fgs_levels_t;

  // Level codes of the four corners, corner k = 2*row_step + col_step.
  typedef struct packed {
    logic [CORNERS-1:0][1:0] kp;
    logic [CORNERS-1:0][1:0] kd;
  } fgs_codes_t;

  localparam fgs_levels_t KP_LEVEL_RESET = {10'd240, 10'd160, 10'd80, 10'd0};
  localparam fgs_levels_t KD_LEVEL_RESET = {10'd600, 10'd400, 10'd200, 10'd0};

  // Rule tables: row follows the error axis, column the rate axis.
  localparam logic [1:0] KP_RULES [0:GRID_N-1][0:GRID_N-1] = '{
    '{2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3},
    '{2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2},
    '{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1},
    '{2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1},
    '{2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1, 2'd0},
    '{2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd0, 2'd2},
    '{2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3}
  };

  localparam logic [1:0] KD_RULES [0:GRID_N-1][0:GRID_N-1] = '{
    '{2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2, 2'd2},
    '{2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1},
    '{2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd2, 2'd1},
    '{2'd1, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1},
    '{2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1},
    '{2'd2, 2'd2, 2'd1, 2'd0, 2'd1, 2'd1, 2'd1},
    '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd3, 2'd2}
  };

endpackage

/* src/fuzzy_gain_scheduler.sv */
`timescale 1ns / 1ps
// ============================================================================
// fuzzy_gain_scheduler - fuzzy PD gain scheduling on a 7x7 rule grid
// Interpolates proportional and derivative gains from the scaled error and
// error rate, using two fixed rule tables and eight programmable levels.
// ============================================================================
// One word is accepted per clock cycle and one result word leaves per cycle
// when the output side does not stall. A word passes from acceptance to
// its result through the front stage, which clamps the inputs, finds the
// grid cell and reads the rule tables, then the two-word queue, and then
// the three back-end stages (corner weight products, multiplication by the
// level values, and the sum with truncation and saturation, whose register
// presents the result). The queue sits between front and back, so the front
// keeps taking words while the back holds a result that has not yet been
// taken; the input stalls only once the front register and the queue are
// full. Level registers are to be written through the cfg port only while
// no word is in flight (the block does not enforce this); writes take effect
// on the next word.
module fuzzy_gain_scheduler #(
  parameter int FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [fgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fgs_pkg::LEVEL_W-1:0]       cfg_data,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [15:0]                in_error_scaled,
  input  logic signed [15:0]                in_rate_scaled,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fgs_pkg::OUT_W-1:0]         out_kp_gain,
  output logic [fgs_pkg::OUT_W-1:0]         out_kd_gain
);
  import fgs_pkg::*;

  localparam int W_W    = FRAC_BITS + 1;
  localparam int CODE_W = $bits(fgs_codes_t);
  localparam int Q_W    = CODE_W + 2 * W_W;

  // Level registers: Kp levels first, then Kd levels, indexed by level code.
  fgs_levels_t kp_lvl_r, kp_lvl_nxt;
  fgs_levels_t kd_lvl_r, kd_lvl_nxt;

  always_comb begin
    kp_lvl_nxt = kp_lvl_r;
    kd_lvl_nxt = kd_lvl_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_KP_ZERO:  kp_lvl_nxt[0] = cfg_data;
        REG_KP_ONE:   kp_lvl_nxt[1] = cfg_data;
        REG_KP_TWO:   kp_lvl_nxt[2] = cfg_data;
        REG_KP_THREE: kp_lvl_nxt[3] = cfg_data;
        REG_KD_ZERO:  kd_lvl_nxt[0] = cfg_data;
        REG_KD_ONE:   kd_lvl_nxt[1] = cfg_data;
        REG_KD_TWO:   kd_lvl_nxt[2] = cfg_data;
        REG_KD_THREE: kd_lvl_nxt[3] = cfg_data;
        default: begin
          kp_lvl_nxt = kp_lvl_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_lvl_r <= KP_LEVEL_RESET;
      kd_lvl_r <= KD_LEVEL_RESET;
    end else begin
      kp_lvl_r <= kp_lvl_nxt;
      kd_lvl_r <= kd_lvl_nxt;
    end
  end

  // Front end to queue.
  logic             fr_valid, fr_full;
  fgs_codes_t       fr_codes;
  logic [W_W-1:0]   fr_we, fr_wc;

  // Queue to back end.
  logic             bk_valid, bk_ready;
  logic [Q_W-1:0]   bk_data;
  fgs_codes_t       bk_codes;
  logic [W_W-1:0]   bk_we, bk_wc;

  fgs_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_error_scaled (in_error_scaled),
    .in_rate_scaled  (in_rate_scaled),
    .fr_valid        (fr_valid),
    .fr_full         (fr_full),
    .fr_codes        (fr_codes),
    .fr_we           (fr_we),
    .fr_wc           (fr_wc)
  );

  fgs_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_full  (fr_full),
    .push_data  ({fr_codes, fr_we, fr_wc}),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_data)
  );

  assign {bk_codes, bk_we, bk_wc} = bk_data;

  fgs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .bk_valid    (bk_valid),
    .bk_ready    (bk_ready),
    .bk_codes    (bk_codes),
    .bk_we       (bk_we),
    .bk_wc       (bk_wc),
    .kp_levels   (kp_lvl_r),
    .kd_levels   (kd_lvl_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kp_gain (out_kp_gain),
    .out_kd_gain (out_kd_gain)
  );

endmodule

/* src/fgs_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// fgs_front - input stage of the fuzzy gain scheduler
// Clamps both inputs onto the grid, splits them into cell and lower weight,
// and looks up the level codes of the four corners in both rule tables.
// ============================================================================
module fgs_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [15:0]        in_error_scaled,
  input  logic signed [15:0]        in_rate_scaled,
  output logic                      fr_valid,
  input  logic                      fr_full,
  output fgs_pkg::fgs_codes_t       fr_codes,
  output logic [FRAC_BITS:0]        fr_we,
  output logic [FRAC_BITS:0]        fr_wc
);
  import fgs_pkg::*;

  localparam int W_W   = FRAC_BITS + 1;
  localparam int ONE_V = 1 << FRAC_BITS;
  localparam logic signed [17:0] EDGE_P = 18'(3 * ONE_V);
  localparam logic signed [17:0] EDGE_N = 18'(-3 * ONE_V);
  localparam logic [17:0]        FRAC_MASK = 18'(ONE_V - 1);

  // Returns {cell, lower weight}.
  function automatic logic [W_W+2:0] split_axis(input logic signed [15:0] x);
    logic signed [17:0] xe;
    logic [17:0]        t;
    logic [2:0]         cidx;
    logic [W_W-1:0]     w;
    xe = 18'(x);
    t  = 18'(xe + EDGE_P);
    if (xe < EDGE_N) begin
      cidx = 3'd0;
      w    = W_W'(ONE_V);
    end else if (xe >= EDGE_P) begin
      cidx = CELL_MAX;
      w    = '0;
    end else begin
      cidx = 3'(t >> FRAC_BITS);
      w    = W_W'(ONE_V) - W_W'(t & FRAC_MASK);
    end
    return {cidx, w};
  endfunction

  logic [2:0]      ce, cc;
  logic [W_W-1:0]  we, wc;
  fgs_codes_t      codes;
  logic            acc;
  logic            push;

  logic            fr_v_r, fr_v_nxt;
  fgs_codes_t      codes_r;
  logic [W_W-1:0]  we_r, wc_r;

  always_comb begin
    {ce, we} = split_axis(in_error_scaled);
    {cc, wc} = split_axis(in_rate_scaled);
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        codes.kp[2*i+j] = KP_RULES[ce + 3'(i)][cc + 3'(j)];
        codes.kd[2*i+j] = KD_RULES[ce + 3'(i)][cc + 3'(j)];
      end
    end
  end

  assign in_stall = fr_v_r & fr_full;
  assign acc      = in_valid & ~in_stall;
  assign push     = fr_v_r & ~fr_full;

  always_comb begin
    fr_v_nxt = fr_v_r;
    if (acc) begin
      fr_v_nxt = 1'b1;
    end else if (push) begin
      fr_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      codes_r <= codes;
      we_r    <= we;
      wc_r    <= wc;
    end
  end

  assign fr_valid = fr_v_r;
  assign fr_codes = codes_r;
  assign fr_we    = we_r;
  assign fr_wc    = wc_r;

endmodule

/* src/fgs_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// fgs_queue - short queue between the front and the back end
// A small first-in first-out buffer of classified words.
// ============================================================================
module fgs_queue #(
  parameter int DATA_W = 34
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_full,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);
  import fgs_pkg::*;

  logic [DATA_W-1:0] mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  assign push_full = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign push      = push_valid & ~push_full;
  assign pop       = pop_valid & pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/fgs_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// fgs_back - arithmetic back end of the fuzzy gain scheduler
// Three stages: corner weight products with level selection, level
// multiplication, then sum, truncation and saturation into the output word.
// ============================================================================
module fgs_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        bk_valid,
  output logic                        bk_ready,
  input  fgs_pkg::fgs_codes_t         bk_codes,
  input  logic [FRAC_BITS:0]          bk_we,
  input  logic [FRAC_BITS:0]          bk_wc,
  input  fgs_pkg::fgs_levels_t        kp_levels,
  input  fgs_pkg::fgs_levels_t        kd_levels,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fgs_pkg::OUT_W-1:0]   out_kp_gain,
  output logic [fgs_pkg::OUT_W-1:0]   out_kd_gain
);
  import fgs_pkg::*;

  localparam int W_W   = FRAC_BITS + 1;
  localparam int ONE_V = 1 << FRAC_BITS;
  localparam int PW    = 2 * W_W;
  localparam int MW    = PW + LEVEL_W;
  localparam int SUM_W = MW + 2;
  localparam int SH_W  = SUM_W - FRAC_BITS;
  localparam logic [SH_W-1:0] SAT_LIM = SH_W'(OUT_MAX);

  logic rdy1, rdy2, rdy3;
  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;

  logic [W_W-1:0] w_e [2];
  logic [W_W-1:0] w_c [2];

  logic [PW-1:0]   prod_nxt [CORNERS];
  logic [PW-1:0]   prod_r   [CORNERS];
  fgs_level_t      lkp_r    [CORNERS];
  fgs_level_t      lkd_r    [CORNERS];
  logic [MW-1:0]   mkp_r    [CORNERS];
  logic [MW-1:0]   mkd_r    [CORNERS];

  logic [SUM_W-1:0] sum_kp, sum_kd;
  logic [SH_W-1:0]  sh_kp, sh_kd;
  logic [OUT_W-1:0] kp_nxt, kd_nxt;
  logic [OUT_W-1:0] kp_r, kd_r;

  // Each stage moves on when the one after it is empty or moving.
  assign rdy3     = ~v3_r | ~out_stall;
  assign rdy2     = ~v2_r | rdy3;
  assign rdy1     = ~v1_r | rdy2;
  assign bk_ready = rdy1;

  always_comb begin
    v1_nxt = rdy1 ? bk_valid : v1_r;
    v2_nxt = rdy2 ? v1_r     : v2_r;
    v3_nxt = rdy3 ? v2_r     : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Stage 1: corner weights.
  always_comb begin
    w_e[0] = bk_we;
    w_e[1] = W_W'(ONE_V) - bk_we;
    w_c[0] = bk_wc;
    w_c[1] = W_W'(ONE_V) - bk_wc;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        prod_nxt[2*i+j] = PW'(w_e[i]) * PW'(w_c[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int k = 0; k < CORNERS; k++) begin
        prod_r[k] <= prod_nxt[k];
        lkp_r[k]  <= kp_levels[bk_codes.kp[k]];
        lkd_r[k]  <= kd_levels[bk_codes.kd[k]];
      end
    end
  end

  // Stage 2: weighted levels.
  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int k = 0; k < CORNERS; k++) begin
        mkp_r[k] <= MW'(prod_r[k]) * MW'(lkp_r[k]);
        mkd_r[k] <= MW'(prod_r[k]) * MW'(lkd_r[k]);
      end
    end
  end

  // Stage 3: sum, drop FRAC_BITS fraction bits of the weight product, saturate.
  always_comb begin
    sum_kp = SUM_W'(mkp_r[0]) + SUM_W'(mkp_r[1]) + SUM_W'(mkp_r[2]) + SUM_W'(mkp_r[3]);
    sum_kd = SUM_W'(mkd_r[0]) + SUM_W'(mkd_r[1]) + SUM_W'(mkd_r[2]) + SUM_W'(mkd_r[3]);
    sh_kp  = SH_W'(sum_kp >> FRAC_BITS);
    sh_kd  = SH_W'(sum_kd >> FRAC_BITS);
    kp_nxt = (sh_kp > SAT_LIM) ? OUT_MAX : OUT_W'(sh_kp);
    kd_nxt = (sh_kd > SAT_LIM) ? OUT_MAX : OUT_W'(sh_kd);
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      kp_r <= kp_nxt;
      kd_r <= kd_nxt;
    end
  end

  assign out_valid   = v3_r;
  assign out_kp_gain = kp_r;
  assign out_kd_gain = kd_r;

endmodule

/* src/fgs_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// fgs_port_checks - port-level checks of the fuzzy gain scheduler
// Watches the handshakes of the top level and flags broken behaviour.
// ============================================================================
module fgs_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [17:0] out_kp_gain,
  input logic [17:0] out_kd_gain
);

  // Reset empties the pipeline.
  ap_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // A stalled result word stays put.
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kp_gain) && $stable(out_kd_gain))
    else $error("stalled result word changed");

  // With the output empty now and at the sample before, the queue has drained below full.
  ap_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!out_valid) && $past(rst_n) |-> !in_stall)
    else $error("input stalled although the back end is free");

endmodule

bind fuzzy_gain_scheduler fgs_port_checks u_fgs_port_checks (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_kp_gain (out_kp_gain),
  .out_kd_gain (out_kd_gain)
);
